// ===== rtl/twcr_pkg.sv =====
// ----------------------------------------------------------------------------
// twcr_pkg
// Shared constants and types of the two-wire character receiver.
// ----------------------------------------------------------------------------
package twcr_pkg;

  // longest message kept, in characters
  localparam int unsigned MAX_CHARS = 64;
  // width of the message length counter, able to hold MAX_CHARS itself
  localparam int unsigned TEXT_W    = $clog2(MAX_CHARS + 1);

  // field widths
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned INDEX_W   = 6;
  localparam int unsigned LENGTH_W  = 7;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  // last bit position of the character before the parity bit
  localparam logic [2:0] LAST_DATA_BIT = 3'd6;

  // register reset values
  localparam logic [LENGTH_W-1:0] MIN_LEN_RESET = 7'd9;

  // register indexes
  localparam logic REG_MIN_LEN = 1'b0;

  // edge event codes
  localparam logic [1:0] OP_CLK_FALL  = 2'd0;
  localparam logic [1:0] OP_CLK_RISE  = 2'd1;
  localparam logic [1:0] OP_DATA_FALL = 2'd2;
  localparam logic [1:0] OP_DATA_RISE = 2'd3;

  // one result beat
  typedef struct packed {
    logic                line_drive;
    logic                line_value;
    logic                char_valid;
    logic [CHAR_W-1:0]   char_value;
    logic [INDEX_W-1:0]  char_index;
    logic                message_done;
    logic [LENGTH_W-1:0] message_length;
  } result_t;

endpackage

// ===== rtl/twcr_cfg.sv =====
// ----------------------------------------------------------------------------
// twcr_cfg
// APB register file holding the hand-off length threshold.
// ----------------------------------------------------------------------------
module twcr_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [twcr_pkg::PADDR_W-1:0]      paddr,
  input  logic [twcr_pkg::PDATA_W-1:0]      pwdata,
  output logic [twcr_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  output logic [twcr_pkg::LENGTH_W-1:0]     min_len_o
);

  logic                          wr_en;
  logic                          reg_sel;
  logic [twcr_pkg::LENGTH_W-1:0] min_len_q;
  logic [twcr_pkg::LENGTH_W-1:0] min_len_d;

  // register index sits above the byte offset
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready && (reg_sel == twcr_pkg::REG_MIN_LEN);

  // threshold register
  assign min_len_d = wr_en ? pwdata[twcr_pkg::LENGTH_W-1:0] : min_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= twcr_pkg::MIN_LEN_RESET;
    end else begin
      min_len_q <= min_len_d;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (reg_sel == twcr_pkg::REG_MIN_LEN) begin
      prdata[twcr_pkg::LENGTH_W-1:0] = min_len_q;
    end
  end

  assign min_len_o = min_len_q;

endmodule

// ===== rtl/twcr_core.sv =====
// ----------------------------------------------------------------------------
// twcr_core
// Line state tracker: bit shifter, parity check, ack drive and message count.
// ----------------------------------------------------------------------------
module twcr_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [1:0]                    op_i,
  input  logic                          data_level_i,
  input  logic [twcr_pkg::LENGTH_W-1:0] min_len_i,
  output twcr_pkg::result_t             res_o
);

  localparam int unsigned EXT_W = twcr_pkg::TEXT_W + twcr_pkg::LENGTH_W;

  logic                          clk_high_q, clk_high_d;
  logic [2:0]                    bit_pos_q, bit_pos_d;
  logic                          ones_odd_q, ones_odd_d;
  logic [twcr_pkg::CHAR_W-1:0]   shift_q, shift_d;
  logic                          ack_pend_q, ack_pend_d;
  logic                          ack_lvl_q, ack_lvl_d;
  logic                          drive_on_q, drive_on_d;
  logic                          drive_lvl_q, drive_lvl_d;
  logic [twcr_pkg::TEXT_W-1:0]   text_len_q, text_len_d;
  logic [twcr_pkg::TEXT_W-1:0]   len_after;
  logic [EXT_W-1:0]              len_ext;
  logic [EXT_W-1:0]              min_ext;
  logic [EXT_W-1:0]              idx_ext;
  logic [2:0]                    bit_idx;
  logic                          parity_ok;
  logic                          room;
  logic                          appended;
  logic                          done;

  assign bit_idx   = twcr_pkg::LAST_DATA_BIT - bit_pos_q;
  assign parity_ok = (data_level_i == ~ones_odd_q);
  assign room      = (text_len_q < twcr_pkg::TEXT_W'(twcr_pkg::MAX_CHARS));
  assign min_ext   = {{twcr_pkg::TEXT_W{1'b0}}, min_len_i};
  assign idx_ext   = {{twcr_pkg::LENGTH_W{1'b0}}, text_len_q};

  // next state for one event
  always_comb begin
    clk_high_d  = clk_high_q;
    bit_pos_d   = bit_pos_q;
    ones_odd_d  = ones_odd_q;
    shift_d     = shift_q;
    ack_pend_d  = ack_pend_q;
    ack_lvl_d   = ack_lvl_q;
    drive_on_d  = drive_on_q;
    drive_lvl_d = drive_lvl_q;
    len_after   = text_len_q;
    appended    = 1'b0;
    done        = 1'b0;
    case (op_i)
      twcr_pkg::OP_CLK_FALL: begin
        clk_high_d = 1'b0;
      end
      twcr_pkg::OP_CLK_RISE: begin
        clk_high_d = 1'b1;
        if (ack_pend_q) begin
          // release the line after the ack bit
          ack_pend_d = 1'b0;
          drive_on_d = 1'b0;
        end else if (bit_pos_q <= twcr_pkg::LAST_DATA_BIT) begin
          // shift one data bit in, msb first
          shift_d[bit_idx] = data_level_i;
          ones_odd_d       = ones_odd_q ^ data_level_i;
          bit_pos_d        = bit_pos_q + 3'd1;
        end else if (parity_ok) begin
          // parity bit good: append nonzero char if there is room
          if ((shift_q != '0) && room) begin
            appended  = 1'b1;
            len_after = text_len_q + twcr_pkg::TEXT_W'(1);
          end
          ack_lvl_d = 1'b1;
        end else begin
          ack_lvl_d = 1'b0;
        end
      end
      twcr_pkg::OP_DATA_FALL: begin
        // drive the ack level and start a new character
        if (!clk_high_q) begin
          drive_on_d  = 1'b1;
          drive_lvl_d = ack_lvl_q;
          bit_pos_d   = '0;
          ones_odd_d  = 1'b0;
          shift_d     = '0;
          ack_pend_d  = 1'b1;
          ack_lvl_d   = 1'b0;
        end
      end
      twcr_pkg::OP_DATA_RISE: begin
        // stop condition hands off a long enough message
        if (clk_high_q && (bit_pos_q == '0) && (idx_ext > min_ext)) begin
          done = 1'b1;
        end
      end
      default: begin
        clk_high_d = clk_high_q;
      end
    endcase
    text_len_d = done ? '0 : len_after;
  end

  assign len_ext = {{twcr_pkg::LENGTH_W{1'b0}}, len_after};

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_high_q  <= 1'b0;
      bit_pos_q   <= '0;
      ones_odd_q  <= 1'b0;
      shift_q     <= '0;
      ack_pend_q  <= 1'b0;
      ack_lvl_q   <= 1'b0;
      drive_on_q  <= 1'b0;
      drive_lvl_q <= 1'b0;
      text_len_q  <= '0;
    end else if (accept_i) begin
      clk_high_q  <= clk_high_d;
      bit_pos_q   <= bit_pos_d;
      ones_odd_q  <= ones_odd_d;
      shift_q     <= shift_d;
      ack_pend_q  <= ack_pend_d;
      ack_lvl_q   <= ack_lvl_d;
      drive_on_q  <= drive_on_d;
      drive_lvl_q <= drive_lvl_d;
      text_len_q  <= text_len_d;
    end
  end

  // result of this event
  always_comb begin
    res_o.line_drive     = drive_on_d;
    res_o.line_value     = drive_on_d & drive_lvl_d;
    res_o.char_valid     = appended;
    res_o.char_value     = appended ? shift_q : '0;
    res_o.char_index     = appended ? idx_ext[twcr_pkg::INDEX_W-1:0] : '0;
    res_o.message_done   = done;
    res_o.message_length = len_ext[twcr_pkg::LENGTH_W-1:0];
  end

endmodule

// ===== rtl/twcr_out_reg.sv =====
// ----------------------------------------------------------------------------
// twcr_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module twcr_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  twcr_pkg::result_t res_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic              busy_o,
  output twcr_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  twcr_pkg::result_t res_q;

  // full while the consumer stalls a held beat
  assign busy_o  = valid_q && out_stall_i;
  assign valid_d = load_i || busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/two_wire_char_receiver.sv =====
// ----------------------------------------------------------------------------
// two_wire_char_receiver
// Decodes clock/data line edge events into parity-checked characters.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_stall_o    op_i, data_level_i
//   out       output     out_valid_o / out_stall_i  line_drive_o .. message_length_o
//   cfg       input      APB psel/penable/pready    threshold at byte address 0
//
// One event per cycle while in_stall_o is low; its result appears in the cycle after acceptance.
// Line state updates at the accepting edge, the result register holds the beat.
// in_stall_o is high only while a result beat is held under out_stall_i.
// Reset clears the line state, the message length and the output valid.
// ----------------------------------------------------------------------------
module two_wire_char_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // event beats
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic                          data_level_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          line_drive_o,
  output logic                          line_value_o,
  output logic                          char_valid_o,
  output logic [twcr_pkg::CHAR_W-1:0]   char_value_o,
  output logic [twcr_pkg::INDEX_W-1:0]  char_index_o,
  output logic                          message_done_o,
  output logic [twcr_pkg::LENGTH_W-1:0] message_length_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [twcr_pkg::PADDR_W-1:0]  paddr,
  input  logic [twcr_pkg::PDATA_W-1:0]  pwdata,
  output logic [twcr_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic                          accept;
  logic                          busy;
  logic [twcr_pkg::LENGTH_W-1:0] min_len;
  twcr_pkg::result_t             res_next;
  twcr_pkg::result_t             res_out;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  // threshold register
  twcr_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .min_len_o (min_len)
  );

  // line state and event decode
  twcr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (op_i),
    .data_level_i (data_level_i),
    .min_len_i    (min_len),
    .res_o        (res_next)
  );

  // result register
  twcr_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res_next),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .busy_o      (busy),
    .res_o       (res_out)
  );

  assign line_drive_o     = res_out.line_drive;
  assign line_value_o     = res_out.line_value;
  assign char_valid_o     = res_out.char_valid;
  assign char_value_o     = res_out.char_value;
  assign char_index_o     = res_out.char_index;
  assign message_done_o   = res_out.message_done;
  assign message_length_o = res_out.message_length;

endmodule

// ===== tb/two_wire_char_receiver_test.sv =====
// ----------------------------------------------------------------------------
// two_wire_char_receiver_test
// Self-checking test of the two-wire character receiver. Edge event beats go
// in through the valid/stall channel with random gaps. The result beats are
// taken with random stalls and a long hold-off. Each result beat is checked
// field by field against a line-state predictor. The threshold register is
// rewritten and read back over the APB port between phases, once the block
// has gone idle.
// ----------------------------------------------------------------------------
module two_wire_char_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import twcr_pkg::*;

  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned LONG_HOLD     = 100;
  localparam int unsigned HOLD_AT_BEAT  = 150;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [PADDR_W-1:0] THRESHOLD_ADDR = {REG_MIN_LEN, 2'b00};

  // predicts the result beat of every accepted event and checks the beats
  class char_receiver_scoreboard;
    logic [LENGTH_W-1:0] threshold;
    bit                  clock_high;
    logic [2:0]          bit_pos;
    logic [2:0]          ones_count;
    logic [CHAR_W-1:0]   char_bits;
    bit                  ack_waiting;
    bit                  ack_level;
    bit                  driving;
    bit                  drive_level;
    logic [LENGTH_W-1:0] text_length;
    result_t             expected_beats[$];
    int unsigned         errors;
    int unsigned         events;
    int unsigned         checked;
    int unsigned         chars;
    int unsigned         handoffs;
    int unsigned         full_drops;
    int unsigned         parity_fails;

    function new();
      threshold    = MIN_LEN_RESET;
      clock_high   = 1'b0;
      bit_pos      = '0;
      ones_count   = '0;
      char_bits    = '0;
      ack_waiting  = 1'b0;
      ack_level    = 1'b0;
      driving      = 1'b0;
      drive_level  = 1'b0;
      text_length  = '0;
      errors       = 0;
      events       = 0;
      checked      = 0;
      chars        = 0;
      handoffs     = 0;
      full_drops   = 0;
      parity_fails = 0;
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    // advance the line state by one accepted event beat
    function void note_event(logic [1:0] op, logic level);
      result_t beat;
      logic    even_ones;
      beat = '0;
      events++;
      case (op)
        OP_CLK_FALL: clock_high = 1'b0;
        OP_CLK_RISE: begin
          clock_high = 1'b1;
          if (ack_waiting) begin
            // this rise only releases the acknowledge
            ack_waiting = 1'b0;
            driving     = 1'b0;
          end else if (bit_pos <= LAST_DATA_BIT) begin
            char_bits[LAST_DATA_BIT - bit_pos] = level;
            if (level) ones_count++;
            bit_pos++;
          end else begin
            // parity bit, checked again on every further rise
            even_ones = ~ones_count[0];
            if (level == even_ones) begin
              if (char_bits != '0 && text_length < MAX_CHARS) begin
                beat.char_valid = 1'b1;
                beat.char_value = char_bits;
                beat.char_index = text_length[INDEX_W-1:0];
                text_length++;
                chars++;
              end else if (char_bits != '0) begin
                full_drops++;
              end
              ack_level = 1'b1;
            end else begin
              ack_level = 1'b0;
              parity_fails++;
            end
          end
        end
        OP_DATA_FALL: begin
          // start of a character, acknowledge driven while clock is low
          if (!clock_high) begin
            driving     = 1'b1;
            drive_level = ack_level;
            bit_pos     = '0;
            ones_count  = '0;
            char_bits   = '0;
            ack_waiting = 1'b1;
            ack_level   = 1'b0;
          end
        end
        OP_DATA_RISE: begin
          // stop condition
          if (clock_high && bit_pos == '0 && text_length > threshold)
            beat.message_done = 1'b1;
        end
      endcase
      beat.message_length = text_length;
      if (beat.message_done) begin
        text_length = '0;
        handoffs++;
      end
      beat.line_drive = driving;
      beat.line_value = driving & drive_level;
      expected_beats.push_back(beat);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    // check one result beat against the oldest prediction
    function void check_beat(result_t got);
      result_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, got %p", $time, got);
        return;
      end
      want = expected_beats.pop_front();
      checked++;
      compare_field("line_drive", want.line_drive, got.line_drive);
      compare_field("line_value", want.line_value, got.line_value);
      compare_field("char_valid", want.char_valid, got.char_valid);
      compare_field("char_value", want.char_value, got.char_value);
      compare_field("char_index", want.char_index, got.char_index);
      compare_field("message_done", want.message_done, got.message_done);
      compare_field("message_length", want.message_length, got.message_length);
    endfunction
  endclass

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           op_i         = OP_CLK_FALL;
  logic                 data_level_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic                 line_drive_o;
  logic                 line_value_o;
  logic                 char_valid_o;
  logic [CHAR_W-1:0]    char_value_o;
  logic [INDEX_W-1:0]   char_index_o;
  logic                 message_done_o;
  logic [LENGTH_W-1:0]  message_length_o;
  logic                 psel         = 1'b0;
  logic                 penable      = 1'b0;
  logic                 pwrite       = 1'b0;
  logic [PADDR_W-1:0]   paddr        = '0;
  logic [PDATA_W-1:0]   pwdata       = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  char_receiver_scoreboard sb;
  int unsigned             events_sent  = 0;
  bit                      sender_calm  = 1'b0;
  bit                      holding_out  = 1'b0;
  int unsigned             phase_count  = 0;

  two_wire_char_receiver i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .data_level_i     (data_level_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .line_drive_o     (line_drive_o),
    .line_value_o     (line_value_o),
    .char_valid_o     (char_valid_o),
    .char_value_o     (char_value_o),
    .char_index_o     (char_index_o),
    .message_done_o   (message_done_o),
    .message_length_o (message_length_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic random_level();
    return 1'($urandom_range(0, 1));
  endfunction

  // offer one event beat after a random gap and wait until it is taken
  task automatic send_event(input logic [1:0] op, input logic level);
    int unsigned gap;
    gap = (sender_calm || holding_out) ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    data_level_i <= level;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_event(op, level);
    events_sent++;
  endtask

  // one framed character, parity mostly right, then repeated parity rises
  task automatic send_character(input int unsigned repeat_hi);
    logic [CHAR_W-1:0] char_bits;
    logic              parity;
    int unsigned       extra;
    char_bits = CHAR_W'($urandom_range(0, 127));
    parity    = ~^char_bits;
    extra     = $urandom_range(0, repeat_hi);
    send_event(OP_CLK_FALL, random_level());
    send_event(OP_DATA_FALL, random_level());
    send_event(OP_CLK_RISE, random_level());
    for (int i = CHAR_W - 1; i >= 0; i--) begin
      send_event(OP_CLK_FALL, random_level());
      send_event(OP_CLK_RISE, char_bits[i]);
    end
    send_event(OP_CLK_FALL, random_level());
    send_event(OP_CLK_RISE, ($urandom_range(0, 9) == 0) ? ~parity : parity);
    repeat (extra) send_event(OP_CLK_RISE, ($urandom_range(0, 15) == 0) ? ~parity : parity);
  endtask

  // framed stop condition
  task automatic send_stop();
    send_event(OP_CLK_FALL, random_level());
    send_event(OP_DATA_FALL, random_level());
    send_event(OP_CLK_RISE, random_level());
    send_event(OP_DATA_RISE, random_level());
  endtask

  // unframed events that break whatever sequence is in progress
  task automatic send_noise();
    int unsigned count;
    count = $urandom_range(1, 6);
    repeat (count) send_event(2'($urandom_range(0, 3)), random_level());
  endtask

  // wait for the block to go idle, then write and read back the threshold
  task automatic configure_threshold(input logic [LENGTH_W-1:0] value);
    logic [PDATA_W-1:0] readback;
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= THRESHOLD_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.threshold = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== PDATA_W'(value)) begin
      sb.errors++;
      $display("%0t: threshold readback expected %0d, got %0d", $time, value, readback);
    end
    phase_count++;
  endtask

  // ignored events, bad and repeated parity, hand-off and a zero character
  task automatic send_directed();
    send_event(OP_DATA_FALL, 1'b0);
    send_event(OP_DATA_RISE, 1'b1);
    send_event(OP_CLK_RISE, 1'b1);
    send_event(OP_DATA_FALL, 1'b0);
    send_event(OP_DATA_RISE, 1'b1);
    repeat (CHAR_W) send_event(OP_CLK_RISE, 1'b1);
    send_event(OP_CLK_RISE, 1'b1);
    send_event(OP_CLK_RISE, 1'b0);
    send_event(OP_CLK_RISE, 1'b0);
    send_event(OP_CLK_FALL, 1'b0);
    send_event(OP_DATA_FALL, 1'b1);
    send_event(OP_CLK_RISE, 1'b1);
    send_event(OP_DATA_RISE, 1'b1);
    send_event(OP_CLK_FALL, 1'b1);
    send_event(OP_DATA_FALL, 1'b0);
    send_event(OP_CLK_RISE, 1'b0);
    repeat (CHAR_W) send_event(OP_CLK_RISE, 1'b0);
    send_event(OP_CLK_RISE, 1'b1);
  endtask

  // one threshold setting with a random mix of framed and broken sequences
  task automatic run_phase(input logic [LENGTH_W-1:0] threshold, input int unsigned items,
                           input int unsigned repeat_hi, input bit calm);
    int unsigned phase_end;
    int unsigned pick;
    configure_threshold(threshold);
    sender_calm = calm;
    phase_end   = events_sent + items;
    while (events_sent < phase_end) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) send_character(repeat_hi);
      else if (pick < 80) send_stop();
      else send_noise();
    end
  endtask

  // main stimulus
  initial begin : stimulus
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    configure_threshold(LENGTH_W'(0));
    send_directed();
    // threshold out of reach, so the message runs full
    run_phase(LENGTH_W'(64), 330, 12, 1'b0);
    // first stop hands off the full message
    run_phase(LENGTH_W'(63), 120, 3, 1'b1);
    run_phase(LENGTH_W'(0), 140, 3, 1'b0);
    run_phase(LENGTH_W'($urandom_range(1, 12)), 150, 4, 1'b1);
    run_phase(MIN_LEN_RESET, 180, 6, 1'b0);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("run covered %0d events over %0d threshold settings, %0d result beats checked",
             sb.events, phase_count, sb.checked);
    $display("%0d characters appended, %0d hand-offs, %0d lost to a full message, %0d parity errors",
             sb.chars, sb.handoffs, sb.full_drops, sb.parity_fails);
    if (sb.errors == 0)
      $display("two_wire_char_receiver_test: done, clean");
    else
      $display("two_wire_char_receiver_test: done, errors");
    $finish;
  end

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned beats;
    bit          calm;
    result_t     got;
    stall_left = 0;
    hold_left  = 0;
    beats      = 0;
    calm       = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.line_drive     = line_drive_o;
        got.line_value     = line_value_o;
        got.char_valid     = char_valid_o;
        got.char_value     = char_value_o;
        got.char_index     = char_index_o;
        got.message_done   = message_done_o;
        got.message_length = message_length_o;
        sb.check_beat(got);
        beats++;
        if (beats % 40 == 0) calm = 1'($urandom_range(0, 1));
        stall_left = calm ? 0 : $urandom_range(0, 15);
        if (beats == HOLD_AT_BEAT) begin
          hold_left   = LONG_HOLD;
          holding_out = 1'b1;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        holding_out = 1'b0;
        out_stall_i <= 1'b0;
      end
    end
  end

  // ends the run when no beat moves on either channel for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
    $display("two_wire_char_receiver_test: done, errors");
    $finish;
  end

endmodule
